[rtl/fmacl_pkg.sv]
// ----------------------------------------------------------------------------
// fmacl_pkg
// Shared types and constants for the first-match packet access control list:
// table size, operation and action codes, and the beat that walks the chain.
// ----------------------------------------------------------------------------
package fmacl_pkg;

  localparam int MAX_RULES  = 16;
  localparam int RULE_IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W      = $clog2(MAX_RULES + 1);

  localparam int OUT_IDX_W  = 4;
  localparam int OUT_CNT_W  = 5;

  localparam logic [7:0] PROTO_ANY = 8'd250;
  localparam logic [15:0] PORT_ANY = 16'd0;

  localparam logic [1:0] ACT_ACCEPT = 2'd0;
  localparam logic [1:0] ACT_DROP   = 2'd1;
  localparam logic [1:0] ACT_DEFER  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_APPEND   = 2'd1,
    OP_LOCK     = 2'd2,
    OP_UNLOCK   = 2'd3
  } op_t;

  // One item as it moves from cell to cell.
  typedef struct packed {
    op_t                   op;
    logic [31:0]           src_addr;
    logic [31:0]           dst_addr;
    logic [15:0]           dst_port;
    logic [7:0]            protocol;
    logic                  src_any;
    logic                  dst_any;
    logic [1:0]            rule_action;
    logic                  locked;
    logic [CNT_W-1:0]      held;        // rules in force, or write slot on append
    logic [CNT_W-1:0]      count_after;
    logic                  full;
    logic                  hit;
    logic [RULE_IDX_W-1:0] hit_idx;
    logic [1:0]            hit_act;
  } beat_t;

endpackage

[rtl/fmacl_cell.sv]
// ----------------------------------------------------------------------------
// fmacl_cell
// One rule slot of the chain. Holds a rule, stores it when the matching append
// beat passes, and marks the first hit on classify beats going through.
// ----------------------------------------------------------------------------
module fmacl_cell
  import fmacl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic [RULE_IDX_W-1:0] cell_index,
  input  logic                  valid_in,
  input  beat_t                 beat_in,
  output logic                  valid_out,
  output beat_t                 beat_out
);

  logic [31:0] rule_src;
  logic        rule_src_any;
  logic [31:0] rule_dst;
  logic        rule_dst_any;
  logic [15:0] rule_port;
  logic [7:0]  rule_proto;
  logic [1:0]  rule_act;

  logic  write_en;
  logic  check_en;
  logic  rule_ok;
  beat_t beat_next;

  assign write_en = adv && valid_in && (beat_in.op == OP_APPEND) && !beat_in.full &&
                    (beat_in.held == CNT_W'(cell_index));

  assign check_en = valid_in && (beat_in.op == OP_CLASSIFY) && !beat_in.locked &&
                    !beat_in.hit && (CNT_W'(cell_index) < beat_in.held);

  assign rule_ok = (rule_src_any || (rule_src == beat_in.src_addr)) &&
                   (rule_dst_any || (rule_dst == beat_in.dst_addr)) &&
                   ((rule_port == PORT_ANY) || (rule_port == beat_in.dst_port)) &&
                   ((rule_proto == PROTO_ANY) || (rule_proto == beat_in.protocol));

  always_comb begin
    beat_next = beat_in;
    if (check_en && rule_ok) begin
      beat_next.hit     = 1'b1;
      beat_next.hit_idx = cell_index;
      beat_next.hit_act = rule_act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
    if (adv) begin
      beat_out <= beat_next;
    end
    if (write_en) begin
      rule_src     <= beat_in.src_addr;
      rule_src_any <= beat_in.src_any;
      rule_dst     <= beat_in.dst_addr;
      rule_dst_any <= beat_in.dst_any;
      rule_port    <= beat_in.dst_port;
      rule_proto   <= beat_in.protocol;
      rule_act     <= beat_in.rule_action;
    end
  end

endmodule

[rtl/first_match_packet_acl.sv]
// Path: an accepted input beat crosses every rule cell register, then m_tdata.
// Throughput: one item per cycle; each beat visits one rule cell per cycle.
// The whole chain holds while a result waits on m_tready.
// Reset: rule count, lock flag, default_drop and all beat valids clear at once;
// rule slots hold nothing meaningful until an append writes them.
// ----------------------------------------------------------------------------
// first_match_packet_acl
// First-match packet classifier built as a chain of rule cells. Table updates
// travel the chain in order with packets, so every packet sees exactly the
// rules that were appended before it since the last lock or unlock.
// ----------------------------------------------------------------------------
module first_match_packet_acl
  import fmacl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data,    // default_drop
  input  logic        s_tvalid,
  output logic        s_tready,
  // src_addr[31:0], dst_addr[63:32], dst_port[79:64], protocol[87:80],
  // src_any[88], dst_any[89], rule_action[91:90], zero fill[95:92]
  input  logic [95:0] s_tdata,
  input  logic [1:0]  s_tuser,     // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  // verdict_drop[0], matched[1], match_index[5:2], rule_count[10:6],
  // table_full[11], zero fill[15:12]
  output logic [15:0] m_tdata
);

  logic             default_drop;
  logic [CNT_W-1:0] rules_held;
  logic             locked;
  logic [CNT_W-1:0] rules_held_next;
  logic             locked_next;
  logic             append_full;

  logic  adv;
  logic  valid_chain [0:MAX_RULES];
  beat_t beat_chain  [0:MAX_RULES];
  beat_t in_beat;
  op_t   op_in;

  beat_t last_beat;
  logic  verdict;

  assign cfg_ready = 1'b1;
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign op_in     = op_t'(s_tuser);

  assign append_full = (rules_held >= CNT_W'(MAX_RULES));

  always_comb begin
    rules_held_next = rules_held;
    locked_next     = locked;
    case (op_in)
      OP_CLASSIFY: ;
      OP_APPEND: begin
        if (!append_full) begin
          rules_held_next = rules_held + CNT_W'(1);
        end
      end
      OP_LOCK: begin
        locked_next     = 1'b1;
        rules_held_next = '0;
      end
      OP_UNLOCK: begin
        locked_next     = 1'b0;
        rules_held_next = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    in_beat.op          = op_in;
    in_beat.src_addr    = s_tdata[31:0];
    in_beat.dst_addr    = s_tdata[63:32];
    in_beat.dst_port    = s_tdata[79:64];
    in_beat.protocol    = s_tdata[87:80];
    in_beat.src_any     = s_tdata[88];
    in_beat.dst_any     = s_tdata[89];
    in_beat.rule_action = s_tdata[91:90];
    in_beat.locked      = locked;
    in_beat.held        = rules_held;
    in_beat.count_after = rules_held_next;
    in_beat.full        = (op_in == OP_APPEND) && append_full;
    in_beat.hit         = 1'b0;
    in_beat.hit_idx     = '0;
    in_beat.hit_act     = ACT_DEFER;
  end
  assign beat_chain[0]  = in_beat;
  assign valid_chain[0] = s_tvalid;

  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    fmacl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .cell_index (RULE_IDX_W'(g)),
      .valid_in   (valid_chain[g]),
      .beat_in    (beat_chain[g]),
      .valid_out  (valid_chain[g+1]),
      .beat_out   (beat_chain[g+1])
    );
  end

  assign last_beat = beat_chain[MAX_RULES];

  always_comb begin
    verdict = 1'b0;
    if (last_beat.op == OP_CLASSIFY) begin
      if (last_beat.locked) begin
        verdict = 1'b1;
      end else if (!last_beat.hit || (last_beat.hit_act == ACT_DEFER)) begin
        verdict = default_drop;
      end else begin
        verdict = (last_beat.hit_act == ACT_DROP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_drop <= 1'b0;
      rules_held   <= '0;
      locked       <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        default_drop <= cfg_data[0];
      end
      if (s_tvalid && s_tready) begin
        rules_held <= rules_held_next;
        locked     <= locked_next;
      end
      if (adv) begin
        m_tvalid <= valid_chain[MAX_RULES];
      end
    end
    if (adv) begin
      m_tdata <= {4'd0,
                  last_beat.full,
                  OUT_CNT_W'(last_beat.count_after),
                  OUT_IDX_W'(last_beat.hit_idx),
                  last_beat.hit,
                  verdict};
    end
  end

endmodule

[rtl/fmacl_checker.sv]
// ----------------------------------------------------------------------------
// fmacl_checker
// Port-level checks on the classifier's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module fmacl_checker
  import fmacl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10:6] <= OUT_CNT_W'(MAX_RULES)))
    else $error("rule count beyond table size");

  // A rejected append leaves a full table and carries no classify result.
  a_full_table: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |->
      (m_tdata[10:6] == OUT_CNT_W'(MAX_RULES)) && !m_tdata[1] && !m_tdata[0])
    else $error("table_full with inconsistent fields");

  // A hit needs a held rule.
  a_match_needs_rule: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> (m_tdata[10:6] != '0) && !m_tdata[11])
    else $error("match reported with empty table");

endmodule

bind first_match_packet_acl fmacl_checker u_fmacl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
